### hdl/rlcs_pkg.sv
package rlcs_pkg;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int POS_W    = 10;
    localparam int LETTER_W = 5;
    localparam int CFG_W    = 11;
    localparam int CNT_W    = 11;

    // defaults for the top level parameters
    localparam int MAX_LEN_DEF  = 1024;
    localparam int ALPHABET_DEF = 26;

    localparam logic [CFG_W-1:0] TEXT_LEN_RESET = 11'd1024;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_TEXT_LENGTH = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_SORT  = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    // count memory control from the sequencer
    typedef struct packed {
        logic clear;
        logic we;
    } t_cnt_ctl;

endpackage

### hdl/rlcs_text_mem.sv
module rlcs_text_mem #(
    parameter int DEPTH = rlcs_pkg::MAX_LEN_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [rlcs_pkg::LETTER_W-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [rlcs_pkg::LETTER_W-1:0] o_rdata
);

    logic [rlcs_pkg::LETTER_W-1:0] r_mem [DEPTH];
    logic [rlcs_pkg::LETTER_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rlcs_count_mem.sv
module rlcs_count_mem #(
    parameter int ALPHABET = rlcs_pkg::ALPHABET_DEF,
    parameter int CA_W     = $clog2(ALPHABET)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rlcs_pkg::t_cnt_ctl         i_ctl,
    input  logic [CA_W-1:0]            i_raddr,
    input  logic [CA_W-1:0]            i_waddr,
    input  logic [rlcs_pkg::CNT_W-1:0] i_wdata,
    output logic [rlcs_pkg::CNT_W-1:0] o_rdata
);

    logic [rlcs_pkg::CNT_W-1:0] r_mem [ALPHABET];
    logic [rlcs_pkg::CNT_W-1:0] r_rdata;
    logic [rlcs_pkg::CNT_W-1:0] r_fwd_data;
    logic [ALPHABET-1:0]        r_valid;
    logic                       r_rd_valid;
    logic                       r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata    <= r_mem[i_raddr];
        r_fwd_data <= i_wdata;
    end

    // valid bits stand for the per-sort clear; same-entry write forwards
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[i_raddr];
            r_fwd_hit  <= i_ctl.we && (i_raddr == i_waddr);
            if (i_ctl.clear) begin
                r_valid <= '0;
            end else if (i_ctl.we) begin
                r_valid[i_waddr] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_fwd_hit  ? r_fwd_data :
                     r_rd_valid ? r_rdata    : '0;

endmodule

### hdl/rlcs_seq.sv
module rlcs_seq #(
    parameter int MAX_LEN  = rlcs_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = rlcs_pkg::ALPHABET_DEF,
    parameter int AW       = $clog2(MAX_LEN),
    parameter int LW       = (AW + 1 > rlcs_pkg::CFG_W) ? AW + 1 : rlcs_pkg::CFG_W,
    parameter int CA_W     = $clog2(ALPHABET)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rlcs_pkg::CMD_W-1:0]    i_command,
    input  logic [rlcs_pkg::POS_W-1:0]    i_position,
    input  logic [rlcs_pkg::LETTER_W-1:0] i_letter_in,
    input  logic [rlcs_pkg::POS_W-1:0]    i_range_lo,
    input  logic [rlcs_pkg::POS_W-1:0]    i_range_hi,
    input  logic                          i_ascending,
    input  logic [LW-1:0]                 i_len,
    output logic                          o_txt_we,
    output logic [AW-1:0]                 o_txt_waddr,
    output logic [rlcs_pkg::LETTER_W-1:0] o_txt_wdata,
    output logic [AW-1:0]                 o_txt_raddr,
    input  logic [rlcs_pkg::LETTER_W-1:0] i_txt_rdata,
    output rlcs_pkg::t_cnt_ctl            o_cnt_ctl,
    output logic [CA_W-1:0]               o_cnt_raddr,
    output logic [CA_W-1:0]               o_cnt_waddr,
    output logic [rlcs_pkg::CNT_W-1:0]    o_cnt_wdata,
    input  logic [rlcs_pkg::CNT_W-1:0]    i_cnt_rdata,
    output logic                          o_res_valid,
    output logic [rlcs_pkg::LETTER_W-1:0] o_res_letter,
    output logic                          o_res_error,
    input  logic                          i_res_ready
);

    localparam int PW = AW + 1;
    localparam int LXW = rlcs_pkg::LETTER_W + 1;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_READ      = 7'b0000010,
        S_COUNT     = 7'b0000100,
        S_FILL_REQ  = 7'b0001000,
        S_FILL_LOAD = 7'b0010000,
        S_FILL_WR   = 7'b0100000,
        S_PUSH      = 7'b1000000
    } t_state;

    t_state                        r_state, n_state;
    logic [PW-1:0]                 r_pos;
    logic [PW-1:0]                 r_lo;
    logic [PW-1:0]                 r_hi;
    logic                          r_up;
    logic                          r_issue_done;
    logic                          r_vb;
    logic                          r_vc;
    logic [CA_W-1:0]               r_letter_c;
    logic [CA_W-1:0]               r_k;
    logic [rlcs_pkg::CNT_W-1:0]    r_n;
    logic [rlcs_pkg::LETTER_W-1:0] r_res_letter;
    logic                          r_res_err;

    logic            pos_ok;
    logic            letter_ok;
    logic            range_ok;
    logic            txt_letter_ok;
    logic            accept;
    logic            accept_err;
    logic            count_done;
    logic            fill_wr;
    logic            last_letter;
    logic [CA_W-1:0] fill_letter;

    assign accept        = i_in_valid && (r_state == S_IDLE);
    assign pos_ok        = LW'(i_position) < i_len;
    assign letter_ok     = LXW'(i_letter_in) < LXW'(ALPHABET);
    assign range_ok      = (i_range_lo <= i_range_hi) && (LW'(i_range_hi) < i_len);
    assign txt_letter_ok = LXW'(i_txt_rdata) < LXW'(ALPHABET);
    assign count_done    = r_issue_done && !r_vb && !r_vc;
    assign fill_wr       = (r_n != '0) && (r_pos <= r_hi);
    assign last_letter   = r_k == CA_W'(ALPHABET - 1);
    assign fill_letter   = r_up ? r_k : CA_W'(ALPHABET - 1) - r_k;

    always_comb begin
        case (i_command)
            rlcs_pkg::CMD_WRITE: accept_err = !(pos_ok && letter_ok);
            rlcs_pkg::CMD_SORT:  accept_err = !range_ok;
            rlcs_pkg::CMD_READ:  accept_err = !pos_ok;
            default:             accept_err = 1'b1;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        o_txt_we    = 1'b0;
        o_txt_waddr = r_pos[AW-1:0];
        o_txt_wdata = rlcs_pkg::LETTER_W'(fill_letter);
        o_txt_raddr = r_pos[AW-1:0];
        o_cnt_ctl   = '0;
        o_cnt_raddr = fill_letter;
        o_cnt_waddr = r_letter_c;
        o_cnt_wdata = i_cnt_rdata + rlcs_pkg::CNT_W'(1);
        case (r_state)
            S_IDLE: begin
                o_txt_raddr = AW'(i_position);
                o_txt_waddr = AW'(i_position);
                o_txt_wdata = i_letter_in;
                if (i_in_valid) begin
                    n_state = S_PUSH;
                    case (i_command)
                        rlcs_pkg::CMD_WRITE: begin
                            o_txt_we = !accept_err;
                        end
                        rlcs_pkg::CMD_SORT: begin
                            if (!accept_err) begin
                                o_cnt_ctl.clear = 1'b1;
                                n_state = S_COUNT;
                            end
                        end
                        rlcs_pkg::CMD_READ: begin
                            if (!accept_err) begin
                                n_state = S_READ;
                            end
                        end
                        default: n_state = S_PUSH;
                    endcase
                end
            end
            S_READ: n_state = S_PUSH;
            S_COUNT: begin
                // stage b: letter back from text, look up its count
                if (r_vb && txt_letter_ok) begin
                    o_cnt_raddr = CA_W'(i_txt_rdata);
                end
                // stage c: bump the count
                o_cnt_ctl.we = r_vc;
                if (count_done) begin
                    n_state = S_FILL_REQ;
                end
            end
            S_FILL_REQ:  n_state = S_FILL_LOAD;
            S_FILL_LOAD: n_state = S_FILL_WR;
            S_FILL_WR: begin
                if (fill_wr) begin
                    o_txt_we = 1'b1;
                end else if (last_letter) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_FILL_REQ;
                end
            end
            S_PUSH: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_vb         <= 1'b0;
            r_vc         <= 1'b0;
            r_issue_done <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_COUNT) begin
                r_vb <= !r_issue_done;
                r_vc <= r_vb && txt_letter_ok;
                if (!r_issue_done && (r_pos == r_hi)) begin
                    r_issue_done <= 1'b1;
                end
            end else begin
                r_vb         <= 1'b0;
                r_vc         <= 1'b0;
                r_issue_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_pos        <= PW'(i_range_lo);
                    r_lo         <= PW'(i_range_lo);
                    r_hi         <= PW'(i_range_hi);
                    r_up         <= i_ascending;
                    r_res_letter <= '0;
                    r_res_err    <= accept_err;
                end
            end
            S_READ: r_res_letter <= i_txt_rdata;
            S_COUNT: begin
                if (!r_issue_done && (r_pos != r_hi)) begin
                    r_pos <= r_pos + PW'(1);
                end
                r_letter_c <= CA_W'(i_txt_rdata);
                if (count_done) begin
                    r_pos <= r_lo;
                    r_k   <= '0;
                end
            end
            S_FILL_LOAD: r_n <= i_cnt_rdata;
            S_FILL_WR: begin
                if (fill_wr) begin
                    r_pos <= r_pos + PW'(1);
                    r_n   <= r_n - rlcs_pkg::CNT_W'(1);
                end else if (!last_letter) begin
                    r_k <= r_k + CA_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall   = r_state != S_IDLE;
    assign o_res_valid  = r_state == S_PUSH;
    assign o_res_letter = r_res_letter;
    assign o_res_error  = r_res_err;

endmodule

### hdl/range_letter_counting_sort.sv
// range letter counting sort: a letter buffer with write, read and in-place range sort
//
// input channel: i_in_valid / o_in_stall carry one command per transfer
//   (write letter, sort range, read letter). output channel: o_out_valid /
//   i_out_stall carry one result per command (letter_out, error).
// text_length is written over the apb-style port at byte address 0; write it
//   only while no command is in flight.
// a sort reads the range once to count its letters, then writes it back,
//   fetching each letter's count in turn. the text memory has a single port
//   per direction; one command is worked on at a time.
// at reset the sequencer is idle, the output register is empty, all letter
//   counts read as zero and text_length returns to 1024. text memory holds
//   nothing defined until written.
// while the receiver stalls, the finished result waits in the output register;
//   the next command is still taken and its result waits in the sequencer
//   until the output register frees.
module range_letter_counting_sort #(
    parameter int MAX_LEN  = rlcs_pkg::MAX_LEN_DEF,
    parameter int ALPHABET = rlcs_pkg::ALPHABET_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rlcs_pkg::CMD_W-1:0]    i_command,
    input  logic [rlcs_pkg::POS_W-1:0]    i_position,
    input  logic [rlcs_pkg::LETTER_W-1:0] i_letter_in,
    input  logic [rlcs_pkg::POS_W-1:0]    i_range_lo,
    input  logic [rlcs_pkg::POS_W-1:0]    i_range_hi,
    input  logic                          i_ascending,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rlcs_pkg::LETTER_W-1:0] o_letter_out,
    output logic                          o_error,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rlcs_pkg::APB_AW-1:0]   paddr,
    input  logic [rlcs_pkg::APB_DW-1:0]   pwdata,
    output logic [rlcs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int AW   = $clog2(MAX_LEN);
    localparam int LW   = (AW + 1 > rlcs_pkg::CFG_W) ? AW + 1 : rlcs_pkg::CFG_W;
    localparam int CA_W = $clog2(ALPHABET);

    logic [rlcs_pkg::CFG_W-1:0]    r_text_length;
    logic                          r_out_valid;
    logic [rlcs_pkg::LETTER_W-1:0] r_letter_out;
    logic                          r_error;

    logic [LW-1:0]                 active_len;
    logic                          reg_sel;
    logic                          cfg_wr;

    logic                          txt_we;
    logic [AW-1:0]                 txt_waddr;
    logic [rlcs_pkg::LETTER_W-1:0] txt_wdata;
    logic [AW-1:0]                 txt_raddr;
    logic [rlcs_pkg::LETTER_W-1:0] txt_rdata;

    rlcs_pkg::t_cnt_ctl            cnt_ctl;
    logic [CA_W-1:0]               cnt_raddr;
    logic [CA_W-1:0]               cnt_waddr;
    logic [rlcs_pkg::CNT_W-1:0]    cnt_wdata;
    logic [rlcs_pkg::CNT_W-1:0]    cnt_rdata;

    logic                          res_valid;
    logic [rlcs_pkg::LETTER_W-1:0] res_letter;
    logic                          res_error;
    logic                          res_ready;

    // register decode by word index, low byte-offset bits ignored
    assign reg_sel = paddr[rlcs_pkg::APB_AW-1] == rlcs_pkg::REG_TEXT_LENGTH;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? rlcs_pkg::APB_DW'(r_text_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_length <= rlcs_pkg::TEXT_LEN_RESET;
        end else if (cfg_wr && reg_sel) begin
            r_text_length <= pwdata[rlcs_pkg::CFG_W-1:0];
        end
    end

    // lengths beyond the buffer act as the full buffer
    assign active_len = (LW'(r_text_length) > LW'(MAX_LEN)) ? LW'(MAX_LEN)
                                                            : LW'(r_text_length);

    rlcs_seq #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET),
        .AW       (AW),
        .LW       (LW),
        .CA_W     (CA_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_letter_in  (i_letter_in),
        .i_range_lo   (i_range_lo),
        .i_range_hi   (i_range_hi),
        .i_ascending  (i_ascending),
        .i_len        (active_len),
        .o_txt_we     (txt_we),
        .o_txt_waddr  (txt_waddr),
        .o_txt_wdata  (txt_wdata),
        .o_txt_raddr  (txt_raddr),
        .i_txt_rdata  (txt_rdata),
        .o_cnt_ctl    (cnt_ctl),
        .o_cnt_raddr  (cnt_raddr),
        .o_cnt_waddr  (cnt_waddr),
        .o_cnt_wdata  (cnt_wdata),
        .i_cnt_rdata  (cnt_rdata),
        .o_res_valid  (res_valid),
        .o_res_letter (res_letter),
        .o_res_error  (res_error),
        .i_res_ready  (res_ready)
    );

    // letter buffer, one write and one registered read per cycle
    rlcs_text_mem #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_text_mem (
        .i_clk   (i_clk),
        .i_we    (txt_we),
        .i_waddr (txt_waddr),
        .i_wdata (txt_wdata),
        .i_raddr (txt_raddr),
        .o_rdata (txt_rdata)
    );

    // per-letter counters, cleared at the start of each sort
    rlcs_count_mem #(
        .ALPHABET (ALPHABET),
        .CA_W     (CA_W)
    ) u_count_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cnt_ctl),
        .i_raddr (cnt_raddr),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .o_rdata (cnt_rdata)
    );

    // output register: loads when empty or when its transfer completes
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_letter_out <= res_letter;
            r_error      <= res_error;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_letter_out = r_letter_out;
    assign o_error      = r_error;

    // a result handed over always shows on the output next cycle
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_ready) |=> o_out_valid)
        else $error("result handed over but output register empty");

    // a rejected command never carries a letter
    a_err_no_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_letter_out == '0))
        else $error("error result with nonzero letter");

    // a command is only taken with no result pending in the sequencer
    a_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !res_valid)
        else $error("command taken while a result is pending");

    // after a transfer the sequencer is busy in the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer not busy after command transfer");

endmodule

### bench/range_letter_counting_sort_test.sv
module range_letter_counting_sort_test;

    // run length and pacing
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int END_SETTLE   = 300;
    localparam int PHASE_SETTLE = 4;

    // command code the block does not define
    localparam logic [rlcs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    // byte address of the text_length register
    localparam logic [rlcs_pkg::APB_AW-1:0] TEXT_LEN_ADDR =
        rlcs_pkg::APB_AW'(4 * int'(rlcs_pkg::REG_TEXT_LENGTH));

    typedef struct {
        logic [rlcs_pkg::CMD_W-1:0]    command;
        logic [rlcs_pkg::POS_W-1:0]    position;
        logic [rlcs_pkg::LETTER_W-1:0] letter;
        logic [rlcs_pkg::POS_W-1:0]    lo;
        logic [rlcs_pkg::POS_W-1:0]    hi;
        logic                          up;
    } t_command;

    typedef struct {
        logic [rlcs_pkg::LETTER_W-1:0] letter;
        logic                          err;
        int                            serial;
    } t_outcome;

    // mirror of the letter buffer; works out the outcome of every accepted command
    class letter_buffer_tracker;
        logic [rlcs_pkg::LETTER_W-1:0] letters [rlcs_pkg::MAX_LEN_DEF];
        bit                            written [rlcs_pkg::MAX_LEN_DEF];
        logic [rlcs_pkg::CFG_W-1:0]    text_len = rlcs_pkg::TEXT_LEN_RESET;
        t_outcome                      outcomes_due [$];
        int                            fails;
        int                            accepted;
        int                            n_write;
        int                            n_read;
        int                            n_sort;
        int                            n_rejected;
        int                            widest_sort;

        function int active_len();
            return (text_len > rlcs_pkg::MAX_LEN_DEF) ? rlcs_pkg::MAX_LEN_DEF
                                                      : int'(text_len);
        endfunction

        function int waiting();
            return outcomes_due.size();
        endfunction

        task report(string msg);
            fails++;
            $display("mismatch %0d: %s", fails, msg);
        endtask

        function void note_command(t_command c);
            int len = active_len();
            logic [rlcs_pkg::CNT_W-1:0] counts [rlcs_pkg::ALPHABET_DEF];
            t_outcome r = '{letter: '0, err: 1'b0, serial: accepted};
            int p;
            int k;
            int n;
            int code;
            int at;
            accepted++;
            case (c.command)
                rlcs_pkg::CMD_WRITE: begin
                    if (c.position >= len || c.letter >= rlcs_pkg::ALPHABET_DEF) begin
                        r.err = 1'b1;
                    end else begin
                        letters[c.position] = c.letter;
                        written[c.position] = 1'b1;
                        n_write++;
                    end
                end
                rlcs_pkg::CMD_SORT: begin
                    if (c.lo > c.hi || c.hi >= len) begin
                        r.err = 1'b1;
                    end else begin
                        for (k = 0; k < rlcs_pkg::ALPHABET_DEF; k++) counts[k] = '0;
                        for (p = int'(c.lo); p <= int'(c.hi); p++) counts[letters[p]]++;
                        at = int'(c.lo);
                        for (k = 0; k < rlcs_pkg::ALPHABET_DEF; k++) begin
                            code = c.up ? k : rlcs_pkg::ALPHABET_DEF - 1 - k;
                            for (n = 0; n < int'(counts[code]); n++) begin
                                letters[at] = rlcs_pkg::LETTER_W'(code);
                                at++;
                            end
                        end
                        n_sort++;
                        if (int'(c.hi) - int'(c.lo) + 1 > widest_sort)
                            widest_sort = int'(c.hi) - int'(c.lo) + 1;
                    end
                end
                rlcs_pkg::CMD_READ: begin
                    if (c.position >= len) begin
                        r.err = 1'b1;
                    end else begin
                        r.letter = letters[c.position];
                        n_read++;
                    end
                end
                default: r.err = 1'b1;
            endcase
            if (r.err) n_rejected++;
            outcomes_due = {outcomes_due, r};
        endfunction

        task check_result(logic [rlcs_pkg::LETTER_W-1:0] letter, logic err);
            t_outcome want;
            if (outcomes_due.size() == 0) begin
                report($sformatf("result letter %0d error %0b with nothing outstanding",
                                 letter, err));
                return;
            end
            want = outcomes_due.pop_front();
            if (letter !== want.letter)
                report($sformatf("command %0d: letter_out %0d, want %0d",
                                 want.serial, letter, want.letter));
            if (err !== want.err)
                report($sformatf("command %0d: error %0b, want %0b",
                                 want.serial, err, want.err));
        endtask
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [rlcs_pkg::CMD_W-1:0]    i_command = '0;
    logic [rlcs_pkg::POS_W-1:0]    i_position = '0;
    logic [rlcs_pkg::LETTER_W-1:0] i_letter_in = '0;
    logic [rlcs_pkg::POS_W-1:0]    i_range_lo = '0;
    logic [rlcs_pkg::POS_W-1:0]    i_range_hi = '0;
    logic                          i_ascending = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [rlcs_pkg::LETTER_W-1:0] o_letter_out;
    logic                          o_error;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [rlcs_pkg::APB_AW-1:0]   paddr = '0;
    logic [rlcs_pkg::APB_DW-1:0]   pwdata = '0;
    logic [rlcs_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    letter_buffer_tracker tracker = new();

    // calm: no idling on either side; hold_req: ask the receiver for one long stall
    bit calm;
    bit hold_req;
    int cycle_count;

    range_letter_counting_sort dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_position   (i_position),
        .i_letter_in  (i_letter_in),
        .i_range_lo   (i_range_lo),
        .i_range_hi   (i_range_hi),
        .i_ascending  (i_ascending),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_letter_out (o_letter_out),
        .o_error      (o_error),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 i_clk = ~i_clk;

    // result side: values read here are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(o_letter_out, o_error);
    end

    // receiver: random stall bursts, free-running stretches, one long hold on request
    initial begin : receiver
        int held;
        forever begin
            if (hold_req) begin
                // long hold so the block fills up and stalls its input
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge i_clk);
            end else if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    // watchdog on the whole run
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("run stopped after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_command make_cmd(logic [rlcs_pkg::CMD_W-1:0] cmd, int pos,
                                          int letter, int lo, int hi, bit up);
        t_command c;
        c.command  = cmd;
        c.position = rlcs_pkg::POS_W'(pos);
        c.letter   = rlcs_pkg::LETTER_W'(letter);
        c.lo       = rlcs_pkg::POS_W'(lo);
        c.hi       = rlcs_pkg::POS_W'(hi);
        c.up       = up;
        return c;
    endfunction

    // one transfer on the command channel; called at a rising edge
    task automatic issue(t_command c);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= c.command;
        i_position  <= c.position;
        i_letter_in <= c.letter;
        i_range_lo  <= c.lo;
        i_range_hi  <= c.hi;
        i_ascending <= c.up;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_command(c);
    endtask

    // drop valid and wait until every outstanding result has been taken
    task automatic settle(int extra);
        i_in_valid <= 1'b0;
        while (tracker.waiting() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [rlcs_pkg::CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TEXT_LEN_ADDR;
        pwdata  <= rlcs_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.text_len = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_check();
        logic [rlcs_pkg::APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TEXT_LEN_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got[rlcs_pkg::CFG_W-1:0] !== tracker.text_len)
            tracker.report($sformatf("text_length reads %0d, want %0d",
                                     got[rlcs_pkg::CFG_W-1:0], tracker.text_len));
        @(posedge i_clk);
    endtask

    // position in one of the two working windows, folded into the active length
    function automatic int window_pos(int len);
        int p;
        p = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(992, 1023);
        if (len > 0 && p >= len) p = $urandom_range(0, len - 1);
        return p;
    endfunction

    // a run of written positions inside the active length, starting from a random one
    function automatic bit pick_range(int len, int span, output int lo, output int hi);
        int spots [$];
        int p;
        int steps;
        for (p = 0; p < len; p++)
            if (tracker.written[p]) spots = {spots, p};
        if (spots.size() == 0) return 1'b0;
        p = spots[$urandom_range(0, spots.size() - 1)];
        lo = p;
        hi = p;
        steps = $urandom_range(0, span);
        while (steps > 0 && hi + 1 < len && tracker.written[hi + 1]) begin
            hi++;
            steps--;
        end
        steps = $urandom_range(0, span / 2);
        while (steps > 0 && lo > 0 && tracker.written[lo - 1]) begin
            lo--;
            steps--;
        end
        return 1'b1;
    endfunction

    // mostly well-formed commands on written data, some rejects and noise
    function automatic t_command random_command();
        int len = tracker.active_len();
        int pick;
        int lo;
        int hi;
        int r;
        t_command c;
        c = make_cmd(rlcs_pkg::CMD_WRITE, $urandom_range(0, 1023), $urandom_range(0, 31),
                     $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            c.command = CMD_UNUSED;
        end else if (pick >= 45 && pick < 72) begin
            if ($urandom_range(0, 4) != 0 && pick_range(len, 0, lo, hi)) begin
                c.command  = rlcs_pkg::CMD_READ;
                c.position = rlcs_pkg::POS_W'(lo);
            end else if (len < rlcs_pkg::MAX_LEN_DEF) begin
                c.command  = rlcs_pkg::CMD_READ;
                c.position = rlcs_pkg::POS_W'($urandom_range(len, 1023));
            end
        end else if (pick >= 72) begin
            c.command = rlcs_pkg::CMD_SORT;
            if ($urandom_range(0, 3) != 0 &&
                pick_range(len, ($urandom_range(0, 9) == 0) ? 160 : 24, lo, hi)) begin
                c.lo = rlcs_pkg::POS_W'(lo);
                c.hi = rlcs_pkg::POS_W'(hi);
            end else if (len < rlcs_pkg::MAX_LEN_DEF && $urandom_range(0, 1)) begin
                // range runs past the active length
                hi = $urandom_range(len, 1023);
                c.hi = rlcs_pkg::POS_W'(hi);
                c.lo = rlcs_pkg::POS_W'($urandom_range(0, hi));
            end else begin
                // reversed range
                lo = $urandom_range(1, 1023);
                c.lo = rlcs_pkg::POS_W'(lo);
                c.hi = rlcs_pkg::POS_W'($urandom_range(0, lo - 1));
            end
        end
        if (c.command == rlcs_pkg::CMD_WRITE) begin
            r = $urandom_range(0, 19);
            if (r < 14)
                c.position = rlcs_pkg::POS_W'(window_pos(len));
            else if (r >= 17 && len < rlcs_pkg::MAX_LEN_DEF)
                c.position = rlcs_pkg::POS_W'($urandom_range(len, 1023));
            // few letters make long runs of equal letters in sorted ranges
            r = $urandom_range(0, 9);
            if (r < 5)
                c.letter = rlcs_pkg::LETTER_W'($urandom_range(0, 25));
            else if (r < 9)
                c.letter = rlcs_pkg::LETTER_W'($urandom_range(0, 3));
            else
                c.letter = rlcs_pkg::LETTER_W'($urandom_range(26, 31));
        end
        return c;
    endfunction

    // new text_length between phases, with the block idle
    task automatic set_length(logic [rlcs_pkg::CFG_W-1:0] value);
        settle(PHASE_SETTLE);
        apb_write(value);
        apb_check();
    endtask

    task automatic random_phase(int count);
        repeat (count) issue(random_command());
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register must come out of reset at 1024
        apb_check();

        // directed part at the reset length: extreme positions and letters
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 0, 0, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 1023, 25, 1023, 1023, 1'b1));
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 1, 12, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 2, 7, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 3, 25, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 4, 0, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 5, 7, 0, 0, 1'b0));
        // letters past the alphabet are refused
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 1, 26, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 6, 31, 1023, 1023, 1'b1));
        issue(make_cmd(rlcs_pkg::CMD_READ, 0, 0, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_READ, 1023, 31, 1023, 1023, 1'b1));
        issue(make_cmd(rlcs_pkg::CMD_READ, 1, 0, 0, 0, 1'b0));
        // sort both ways, then two one-letter ranges, one of them at the top end
        issue(make_cmd(rlcs_pkg::CMD_SORT, 0, 0, 0, 5, 1'b1));
        issue(make_cmd(rlcs_pkg::CMD_READ, 5, 0, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_SORT, 0, 0, 0, 5, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_READ, 0, 0, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_SORT, 0, 0, 3, 3, 1'b1));
        issue(make_cmd(rlcs_pkg::CMD_SORT, 1023, 31, 1023, 1023, 1'b0));
        // reversed ranges
        issue(make_cmd(rlcs_pkg::CMD_SORT, 0, 0, 5, 2, 1'b1));
        issue(make_cmd(rlcs_pkg::CMD_SORT, 0, 0, 1023, 0, 1'b0));
        // unused command with every field at its top
        issue(make_cmd(CMD_UNUSED, 1023, 31, 1023, 1023, 1'b1));
        issue(make_cmd(rlcs_pkg::CMD_READ, 3, 0, 0, 0, 1'b0));

        // length above the buffer size acts as the buffer size
        set_length(11'd2047);
        hold_req = 1'b1;
        random_phase(60);

        // short buffer: positions of the high window fold into the active length
        set_length(11'd48);
        random_phase(60);

        // one position in use
        set_length(11'd1);
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 1, 4, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_SORT, 0, 0, 0, 1, 1'b1));
        random_phase(20);

        // zero length: everything is out of range
        set_length(11'd0);
        issue(make_cmd(rlcs_pkg::CMD_WRITE, 0, 5, 0, 0, 1'b0));
        issue(make_cmd(rlcs_pkg::CMD_SORT, 0, 0, 0, 0, 1'b1));
        random_phase(10);

        set_length(11'd1024);
        hold_req = 1'b1;
        random_phase(80);

        // last stretch runs back to back with no idling
        set_length(11'd1000);
        calm = 1'b1;
        random_phase(40);

        settle(END_SETTLE);
        $display("checked %0d commands: %0d writes, %0d reads, %0d sorts (widest %0d)",
                 tracker.accepted, tracker.n_write, tracker.n_read, tracker.n_sort,
                 tracker.widest_sort);
        $display("%0d refused; text lengths 1024, 2047, 48, 1, 0, 1000; two long result holds",
                 tracker.n_rejected);
        if (tracker.fails == 0 && tracker.waiting() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hdl/rlcs_pkg.sv
hdl/rlcs_text_mem.sv
hdl/rlcs_count_mem.sv
hdl/rlcs_seq.sv
hdl/range_letter_counting_sort.sv
bench/range_letter_counting_sort_test.sv
